### rtl/fvws_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the wavetable synthesizer.
package fvws_pkg;

    localparam int TABLE_SIZE    = 1000;
    localparam int FRACTION_BITS = 16;
    localparam int QUARTER       = TABLE_SIZE / 4;

    localparam int STEP_W     = 26;
    localparam int VOL_W      = 12;
    localparam int SAMPLE_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam longint LIMIT_L = longint'(TABLE_SIZE) << FRACTION_BITS;
    localparam int PH_W  = $clog2(LIMIT_L);
    localparam int IDX_W = PH_W - FRACTION_BITS;
    localparam int J_W   = $clog2(QUARTER + 1);

    localparam int AMP_W      = 15;
    localparam int MAX_VOICES = 8;
    localparam int SUM_W      = AMP_W + 1 + $clog2(MAX_VOICES);
    localparam int STEP_REGS  = 4;

    localparam int VOLUME_SHIFT = 16;
    localparam int OUT_OFFSET   = 2048;
    localparam int OUT_MAX      = 4095;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd4;

    localparam logic [VOL_W-1:0] VOLUME_RESET = 12'd2048;

    typedef logic [0:QUARTER][AMP_W-1:0] t_qtab;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } t_token;

    typedef struct packed {
        logic              wr;
        logic [STEP_W-1:0] data;
    } t_step_wr;

    // Magnitudes of 32767*sin over one quarter turn, entry j at angle (pi/2)*4j/TABLE_SIZE.
    // Fixed-point Taylor series in Q30, evaluated at elaboration only.
    function automatic t_qtab qsin_build();
        t_qtab       tab;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] mag;
        int          j;
        for (j = 0; j <= QUARTER; j++) begin
            r = 64'(4 * j);
            if (r == 64'd0) begin
                mag = 64'd0;
            end else if (r >= 64'(TABLE_SIZE)) begin
                mag = 64'd32767;
            end else begin
                x    = (64'd1686629713 * r) / TABLE_SIZE;
                x2   = (x * x) >> 30;
                acc  = x;
                term = x;
                term = ((term * x2) >> 30) / 64'd6;   acc = acc - term;
                term = ((term * x2) >> 30) / 64'd20;  acc = acc + term;
                term = ((term * x2) >> 30) / 64'd42;  acc = acc - term;
                term = ((term * x2) >> 30) / 64'd72;  acc = acc + term;
                term = ((term * x2) >> 30) / 64'd110; acc = acc - term;
                term = ((term * x2) >> 30) / 64'd156; acc = acc + term;
                term = ((term * x2) >> 30) / 64'd210; acc = acc - term;
                term = ((term * x2) >> 30) / 64'd272; acc = acc + term;
                term = ((term * x2) >> 30) / 64'd342; acc = acc - term;
                mag  = (64'd32767 * acc) >> 30;
                if (mag > 64'd32767) begin
                    mag = 64'd32767;
                end
            end
            tab[j] = mag[AMP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QSIN = qsin_build();

endpackage

### rtl/fvws_cell.sv
`timescale 1ns / 1ps
// One voice cell: phase accumulator, sine lookup and add onto the passing partial sum.
module fvws_cell
    import fvws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_step_wr i_step_wr,
    input  t_token   i_token,
    output t_token   o_token
);

    localparam logic [PH_W:0]    LIMIT_X = (PH_W + 1)'(LIMIT_L);
    localparam logic [IDX_W-1:0] Q1      = IDX_W'(QUARTER);
    localparam logic [IDX_W-1:0] Q2      = IDX_W'(2 * QUARTER);
    localparam logic [IDX_W-1:0] Q3      = IDX_W'(3 * QUARTER);
    localparam logic [J_W-1:0]   QJ      = J_W'(QUARTER);

    logic [PH_W-1:0] r_step;
    logic [PH_W-1:0] r_phase;
    logic [PH_W-1:0] n_step;
    logic [PH_W-1:0] n_phase;
    logic [PH_W:0]   w_step_ext;
    logic [PH_W:0]   w_phase_sum;

    logic                    r_valid_a;
    logic signed [SUM_W-1:0] r_sum_a;

    logic                    r_valid_b;
    logic signed [SUM_W-1:0] r_sum_b;
    logic [J_W-1:0]          r_j;
    logic                    r_neg;
    logic [IDX_W-1:0]        w_idx;
    logic [IDX_W-1:0]        w_off;
    logic [J_W-1:0]          n_j;
    logic                    n_neg;
    logic                    w_mirror;

    logic                    r_valid_c;
    logic signed [SUM_W-1:0] r_sum_c;
    logic [SUM_W-1:0]        w_val;
    logic signed [SUM_W-1:0] n_sum;

    // A step at or above the wrap limit is folded once, so that phase plus step
    // never reaches twice the limit.
    always_comb begin
        w_step_ext = (PH_W + 1)'(i_step_wr.data);
        if (w_step_ext >= LIMIT_X) begin
            n_step = PH_W'(w_step_ext - LIMIT_X);
        end else begin
            n_step = PH_W'(w_step_ext);
        end
        w_phase_sum = {1'b0, r_phase} + {1'b0, r_step};
        if (w_phase_sum >= LIMIT_X) begin
            n_phase = PH_W'(w_phase_sum - LIMIT_X);
        end else begin
            n_phase = PH_W'(w_phase_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_phase   <= '0;
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_token.valid;
            if (i_step_wr.wr) begin
                r_step <= n_step;
                if (i_step_wr.data == '0) begin
                    r_phase <= '0;
                end
            end else if (i_token.valid) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_a <= i_token.sum;
    end

    // Fold the table index into the first quarter; odd quarters run backward,
    // the second half of the turn is negative.
    always_comb begin
        w_idx = r_phase[PH_W-1 -: IDX_W];
        if (w_idx >= Q3) begin
            w_off    = w_idx - Q3;
            w_mirror = 1'b1;
            n_neg    = 1'b1;
        end else if (w_idx >= Q2) begin
            w_off    = w_idx - Q2;
            w_mirror = 1'b0;
            n_neg    = 1'b1;
        end else if (w_idx >= Q1) begin
            w_off    = w_idx - Q1;
            w_mirror = 1'b1;
            n_neg    = 1'b0;
        end else begin
            w_off    = w_idx;
            w_mirror = 1'b0;
            n_neg    = 1'b0;
        end
        if (w_mirror) begin
            n_j = QJ - J_W'(w_off);
        end else begin
            n_j = J_W'(w_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_b <= r_sum_a;
        r_j     <= n_j;
        r_neg   <= n_neg;
    end

    always_comb begin
        w_val = SUM_W'(QSIN[r_j]);
        if (r_neg) begin
            n_sum = r_sum_b - $signed(w_val);
        end else begin
            n_sum = r_sum_b + $signed(w_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
        end else begin
            r_valid_c <= r_valid_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_c <= n_sum;
    end

    assign o_token.valid = r_valid_c;
    assign o_token.sum   = r_sum_c;

endmodule

### rtl/fvws_mix.sv
`timescale 1ns / 1ps
// Output mixer: volume multiply, floor shift, offset and saturation to 0..4095.
module fvws_mix
    import fvws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_token              i_token,
    input  logic [VOL_W-1:0]    i_volume,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_sample
);

    localparam int PROD_W  = SUM_W + VOL_W + 1;
    localparam int SHIFT_W = PROD_W - VOLUME_SHIFT;

    logic                     r_valid_p;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    logic [SHIFT_W-1:0]  w_shifted;
    logic [SHIFT_W:0]    w_biased;
    logic [SAMPLE_W-1:0] n_sample;
    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;

    assign n_prod = i_token.sum * $signed({1'b0, i_volume});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
        end else begin
            r_valid_p <= i_token.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Dropping the low bits of a two's complement product is a floor division.
    always_comb begin
        w_shifted = r_prod[PROD_W-1:VOLUME_SHIFT];
        w_biased  = {w_shifted[SHIFT_W-1], w_shifted} + (SHIFT_W + 1)'(OUT_OFFSET);
        if (w_biased[SHIFT_W]) begin
            n_sample = '0;
        end else if (w_biased[SHIFT_W-1:0] > SHIFT_W'(OUT_MAX)) begin
            n_sample = SAMPLE_W'(OUT_MAX);
        end else begin
            n_sample = w_biased[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_valid_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

### rtl/fvws_fifo.sv
`timescale 1ns / 1ps
// Result queue that holds finished samples until the consumer takes them.
module fvws_fifo
    import fvws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [SAMPLE_W-1:0] i_wr_data,
    input  logic                i_rd_en,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [SAMPLE_W-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                w_pop;

    assign w_pop = i_rd_en && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr_en && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

### rtl/four_voice_wavetable_synth.sv
`timescale 1ns / 1ps
// Four-voice wavetable synthesizer: a tick item runs down a chain of voice cells, then the mixer.
// A tick item passes the phase, index and sum registers of each voice cell, the product and
// sample registers of the mixer and the result queue before its sample can be taken.
// Throughput: one item per cycle; the result queue of 3*VOICE_COUNT+4 entries lets the input run
// on while samples wait, and input stalls only when that many samples are pending or in flight.
// Reset clears all phases and steps and sets the volume to 2048.
module four_voice_wavetable_synth
    import fvws_pkg::*;
#(
    parameter int VOICE_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_tick,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_dac_sample,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QDEPTH = 3 * VOICE_COUNT + 4;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic [VOL_W-1:0]    r_volume;
    logic [CNT_W-1:0]    r_pending;
    logic                w_launch;
    logic                w_pop;
    t_token              w_token [0:VOICE_COUNT];
    logic                w_mix_valid;
    logic [SAMPLE_W-1:0] w_mix_sample;

    // Every launched sample holds a queue slot from acceptance until it is taken,
    // so the pipeline itself never has to stop.
    assign o_stall  = (r_pending == CNT_W'(QDEPTH));
    assign w_launch = i_valid && !o_stall && i_tick;
    assign w_pop    = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume  <= VOLUME_RESET;
            r_pending <= '0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == REG_VOLUME)) begin
                r_volume <= i_cfg_data[VOL_W-1:0];
            end
            if (w_launch && !w_pop) begin
                r_pending <= r_pending + 1'b1;
            end else if (!w_launch && w_pop) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    assign w_token[0].valid = w_launch;
    assign w_token[0].sum   = '0;

    for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
        t_step_wr w_step_wr;
        // Voices past the fourth have no step register and stay silent.
        if (v < STEP_REGS) begin : g_reg
            assign w_step_wr.wr =
                i_cfg_wr_en && (i_cfg_index == REG_STEP_A + CFG_IDX_W'(v));
        end else begin : g_none
            assign w_step_wr.wr = 1'b0;
        end
        assign w_step_wr.data = i_cfg_data[STEP_W-1:0];

        fvws_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step_wr (w_step_wr),
            .i_token   (w_token[v]),
            .o_token   (w_token[v+1])
        );
    end

    fvws_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (w_token[VOICE_COUNT]),
        .i_volume (r_volume),
        .o_valid  (w_mix_valid),
        .o_sample (w_mix_sample)
    );

    fvws_fifo #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_mix_valid),
        .i_wr_data (w_mix_sample),
        .i_rd_en   (w_pop),
        .o_valid   (o_valid),
        .o_rd_data (o_dac_sample)
    );

endmodule
